FILE: rtl/core/nblur_pkg.sv
`default_nettype none

package nblur_pkg;

	// payload and register widths
	localparam int PIX_W       = 24;
	localparam int CH_W        = 8;
	localparam int NUM_CH      = 3;
	localparam int ORG_W       = 12;
	localparam int COLS_W      = 13;
	localparam int ROWS_W      = 9;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;
	localparam int OUT_COORD_W = 13;
	// eight channel values of eight bits each
	localparam int CH_SUM_W    = CH_W + 3;

	typedef logic [PIX_W-1:0] pixel_t;

	// column bank index, counts 0..2
	typedef logic [1:0] bank_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_COL  = 2'd0,
		REG_ORIGIN_ROW  = 2'd1,
		REG_REGION_COLS = 2'd2,
		REG_REGION_ROWS = 2'd3
	} cfg_reg_t;

	function automatic bank_t bank_next(input bank_t b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

	// per channel sum of eight neighbours, divided by eight
	function automatic pixel_t blur_mix(
		input pixel_t p0, input pixel_t p1, input pixel_t p2, input pixel_t p3,
		input pixel_t p4, input pixel_t p5, input pixel_t p6, input pixel_t p7
	);
		logic [CH_SUM_W-1:0] s;
		pixel_t              res;
		res = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			s = CH_SUM_W'(p0[ch*CH_W +: CH_W]) + CH_SUM_W'(p1[ch*CH_W +: CH_W])
			  + CH_SUM_W'(p2[ch*CH_W +: CH_W]) + CH_SUM_W'(p3[ch*CH_W +: CH_W])
			  + CH_SUM_W'(p4[ch*CH_W +: CH_W]) + CH_SUM_W'(p5[ch*CH_W +: CH_W])
			  + CH_SUM_W'(p6[ch*CH_W +: CH_W]) + CH_SUM_W'(p7[ch*CH_W +: CH_W]);
			res[ch*CH_W +: CH_W] = s[CH_SUM_W-1:3];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgb_inplace_neighbour_blur.sv
`default_nettype none

// channel   | direction | handshake         | payload
// ----------+-----------+-------------------+-------------------------------
// input     | in        | in_valid/in_stall | pixel_in
// result    | out       | out_valid/out_stall | out_col, out_row, out_pixel
// config    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one pixel transfer per clock while in_stall is low; the result for the pixel that
// completes a neighbourhood is computed in stage one and then held in the output register
// rate is set by the three column banks: each does one read and one write a cycle
// reset clears position counters, pipeline valids and registers (origin 0,0, 3x3);
// the column banks are not cleared
// in_stall rises only when a result sits in stage one while the output register
// is full and out_stall is high

module rgb_inplace_neighbour_blur
	import nblur_pkg::*;
#(
	parameter int MAX_ROWS   = 256,
	parameter int COORD_BITS = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// pixel input
	input  wire logic                   in_valid,
	output      logic                   in_stall,
	input  wire logic [PIX_W-1:0]       pixel_in,
	// write-back output
	output      logic                   out_valid,
	input  wire logic                   out_stall,
	output      logic [OUT_COORD_W-1:0] out_col,
	output      logic [OUT_COORD_W-1:0] out_row,
	output      logic [PIX_W-1:0]       out_pixel,
	// register writes
	input  wire logic                   cfg_valid,
	output      logic                   cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// row counter and bank address width
	localparam int RW   = $clog2(MAX_ROWS);
	// width able to hold the largest column count 2^COORD_BITS
	localparam int CLW  = (COORD_BITS + 1 > COLS_W) ? COORD_BITS + 1 : COLS_W;
	// width able to hold MAX_ROWS and the row register
	localparam int RLW  = (RW + 1 > ROWS_W) ? RW + 1 : ROWS_W;
	// coordinate adder width
	localparam int AW   = ((COORD_BITS > ORG_W) ? COORD_BITS : ORG_W) + 1;

	localparam logic [CLW-1:0] COLS_MAX = CLW'(1 << COORD_BITS);
	localparam logic [RLW-1:0] ROWS_MAX = RLW'(MAX_ROWS);
	localparam logic [AW-1:0]  CMASK    = AW'((1 << COORD_BITS) - 1);

	// configuration registers
	logic [ORG_W-1:0]  origin_col_q;
	logic [ORG_W-1:0]  origin_row_q;
	logic [COLS_W-1:0] region_cols_q;
	logic [ROWS_W-1:0] region_rows_q;

	// scan position and the bank that receives the current column
	logic [COORD_BITS-1:0] col_q;
	logic [RW-1:0]         row_q;
	bank_t                 nbank_q;

	// effective sizes and position decode
	logic [CLW-1:0] cols_ext, cols_eff, col_ext;
	logic [RLW-1:0] rows_ext, rows_eff, row_ext;
	logic           emit_in, row_last, col_last;
	logic [AW-1:0]  col_abs, row_abs;
	logic           in_acc;

	// stage one
	logic                   s1_valid_q;
	logic                   emit_s1;
	pixel_t                 pix_s1;
	logic [OUT_COORD_W-1:0] col_s1;
	logic [OUT_COORD_W-1:0] row_s1;
	bank_t                  nbank_s1;
	logic [RW-1:0]          waddr_s1;
	pixel_t                 rd_s1 [3];

	// neighbourhood windows, advanced once per item leaving stage one
	pixel_t lwin1_q, lwin2_q;
	pixel_t mwin1_q, mwin2_q;
	pixel_t nwin1_q, nwin2_q;
	pixel_t prev_res_q;
	logic   prev_emit_q;

	bank_t  lbank, mbank;
	pixel_t l0, m0, m2, res_s1;
	logic   s1_adv, wb_en;

	// output register
	logic                   out_valid_q;
	logic [OUT_COORD_W-1:0] out_col_q;
	logic [OUT_COORD_W-1:0] out_row_q;
	pixel_t                 out_pixel_q;

	// ---------------------------------------------------------------------
	// configuration port, always ready
	// ---------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_col_q  <= '0;
			origin_row_q  <= '0;
			region_cols_q <= COLS_W'(3);
			region_rows_q <= ROWS_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_COL:  origin_col_q  <= cfg_data[ORG_W-1:0];
				REG_ORIGIN_ROW:  origin_row_q  <= cfg_data[ORG_W-1:0];
				REG_REGION_COLS: region_cols_q <= cfg_data[COLS_W-1:0];
				REG_REGION_ROWS: region_rows_q <= cfg_data[ROWS_W-1:0];
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// size clamping and position decode, ahead of the input transfer
	// ---------------------------------------------------------------------
	assign cols_ext = CLW'(region_cols_q);
	assign rows_ext = RLW'(region_rows_q);
	assign col_ext  = CLW'(col_q);
	assign row_ext  = RLW'(row_q);

	always_comb begin
		priority if (cols_ext == '0)      cols_eff = CLW'(1);
		else if (cols_ext > COLS_MAX)     cols_eff = COLS_MAX;
		else                              cols_eff = cols_ext;

		priority if (rows_ext == '0)      rows_eff = RLW'(1);
		else if (rows_ext > ROWS_MAX)     rows_eff = ROWS_MAX;
		else                              rows_eff = rows_ext;
	end

	// interior pixel one column left and one row up of the current one
	assign emit_in  = (col_ext >= CLW'(2)) && (col_ext < cols_eff)
	               && (row_ext >= RLW'(2)) && (row_ext < rows_eff);
	assign row_last = (row_ext + RLW'(1)) >= rows_eff;
	assign col_last = (col_ext + CLW'(1)) >= cols_eff;

	// absolute coordinates of the written-back pixel
	assign col_abs = (AW'(origin_col_q) & CMASK) + AW'(col_q) - AW'(1);
	assign row_abs = (AW'(origin_row_q) & CMASK) + AW'(row_q) - AW'(1);

	assign in_stall = s1_valid_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	// bank rotation runs on across frame wraps, so the bank taking new pixels
	// never coincides with the bank taking the write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			nbank_q <= 2'd0;
		end else if (in_acc) begin
			if (row_last) begin
				row_q   <= '0;
				col_q   <= col_last ? '0 : col_q + COORD_BITS'(1);
				nbank_q <= bank_next(nbank_q);
			end else begin
				row_q   <= row_q + RW'(1);
			end
		end
	end

	// ---------------------------------------------------------------------
	// stage one register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			emit_s1  <= emit_in;
			pix_s1   <= pixel_in;
			col_s1   <= col_abs[OUT_COORD_W-1:0];
			row_s1   <= row_abs[OUT_COORD_W-1:0];
			nbank_s1 <= nbank_q;
			// row above the current one in the column to its left, target of the write-back
			waddr_s1 <= row_q - RW'(1);
		end
	end

	// ---------------------------------------------------------------------
	// column banks: the current column, the one to its left (partly
	// filtered) and the one before that (fully filtered). all three are
	// read at the current row; the new pixel or the write-back is stored
	// ---------------------------------------------------------------------
	for (genvar b = 0; b < 3; b++) begin : g_bank
		pixel_t        mem [MAX_ROWS];
		logic          wr_pix, wr_res;
		logic [RW-1:0] wr_addr;
		pixel_t        wr_data;

		assign wr_pix  = in_acc && (nbank_q == bank_t'(b));
		assign wr_res  = wb_en && (mbank == bank_t'(b));
		assign wr_addr = wr_pix ? row_q : waddr_s1;
		assign wr_data = wr_pix ? pixel_in : res_s1;

		always_ff @(posedge clk) begin
			if (wr_pix || wr_res) begin
				mem[wr_addr] <= wr_data;
			end
			if (in_acc) begin
				rd_s1[b] <= mem[row_q];
			end
		end
	end

	// ---------------------------------------------------------------------
	// neighbourhood assembly and filter
	// ---------------------------------------------------------------------
	assign lbank = bank_next(nbank_s1);
	assign mbank = bank_next(lbank);

	always_comb begin
		unique case (lbank)
			2'd0:    l0 = rd_s1[0];
			2'd1:    l0 = rd_s1[1];
			2'd2:    l0 = rd_s1[2];
			default: l0 = rd_s1[0];
		endcase
		unique case (mbank)
			2'd0:    m0 = rd_s1[0];
			2'd1:    m0 = rd_s1[1];
			2'd2:    m0 = rd_s1[2];
			default: m0 = rd_s1[0];
		endcase
	end

	// upper-left-middle neighbour: filtered by the previous item if it emitted
	assign m2     = prev_emit_q ? prev_res_q : mwin2_q;
	assign res_s1 = blur_mix(lwin2_q, lwin1_q, l0, m2, m0, nwin2_q, nwin1_q, pix_s1);

	// items that emit nothing never wait for the output register
	assign s1_adv = s1_valid_q && (!emit_s1 || !out_valid_q || !out_stall);
	assign wb_en  = s1_adv && emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_emit_q <= 1'b0;
		end else if (s1_adv) begin
			prev_emit_q <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			lwin2_q    <= lwin1_q;
			lwin1_q    <= l0;
			mwin2_q    <= mwin1_q;
			mwin1_q    <= m0;
			nwin2_q    <= nwin1_q;
			nwin1_q    <= pix_s1;
			prev_res_q <= res_s1;
		end
	end

	// ---------------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			out_col_q   <= col_s1;
			out_row_q   <= row_s1;
			out_pixel_q <= res_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign out_pixel = out_pixel_q;

`ifndef SYNTHESIS
	a_no_bank_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && wb_en) |-> (nbank_q != mbank))
		else $error("new pixel and write-back aimed at the same column bank");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (s1_valid_q && emit_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		wb_en |=> (out_valid_q && (out_pixel_q == $past(res_s1))))
		else $error("filtered pixel not held in the output register");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_ext < ROWS_MAX)
		else $error("row counter beyond the column bank depth");
`endif

endmodule

`default_nettype wire
